>>> hw/rtl/lfxr_pkg.sv
// Shared types and codes for the length-framed XOR frame receiver.
package lfxr_pkg;

   // Input actions
   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_ARM  = 2'd2;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // End status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_BADSTART = 3'd2;
   localparam logic [2:0] ST_TOOLONG  = 3'd3;
   localparam logic [2:0] ST_NACK     = 3'd4;
   localparam logic [2:0] ST_CHKSUM   = 3'd5;

   // Receive phases
   localparam int          PHASE_W  = 3;
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_LENH  = 3'd2;
   localparam logic [2:0] PH_LENL  = 3'd3;
   localparam logic [2:0] PH_RSP   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_CHK   = 3'd6;

   // Control register indexes
   localparam int          CSR_INDEX_W      = 3;
   localparam logic [2:0] CSR_START_BYTE   = 3'd0;
   localparam logic [2:0] CSR_NACK_CODE    = 3'd1;
   localparam logic [2:0] CSR_FIRST_TMO    = 3'd2;
   localparam logic [2:0] CSR_BYTE_TMO     = 3'd3;
   localparam logic [2:0] CSR_MAX_PAYLOAD  = 3'd4;
   localparam logic [2:0] CSR_CHECK_ENABLE = 3'd5;

   // Register reset values
   localparam logic [7:0]  RST_START_BYTE   = 8'hAA;
   localparam logic [7:0]  RST_NACK_CODE    = 8'h00;
   localparam logic [15:0] RST_FIRST_TMO    = 16'd5000;
   localparam logic [15:0] RST_BYTE_TMO     = 16'd100;
   localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd256;
   localparam logic        RST_CHECK_ENABLE = 1'b1;

   // One result item
   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  rsp_code;
      logic [2:0]  status;
      logic [7:0]  nack_error;
      logic [15:0] data_count;
   } rsp_type;

endpackage

>>> hw/rtl/length_framed_xor_frame_receiver.sv
// Length-framed response receiver with XOR checksum check.
//
// Usage: each req_ item is a received byte, a one-millisecond tick or an arm
// command. An arm starts the wait for the start byte; ticks count against
// the first-byte limit and then the limit between later bytes. The frame is
// start byte, big-endian 16-bit length, response code, length-1 data bytes
// and an XOR checksum over length, code and data bytes. Every data byte gives
// one rsp_ item of kind 0; the frame closes with one item of kind 1 that
// carries the status, code, data count and NACK error byte.
// Throughput: one item per cycle while req_stall is low. Each item updates the
// frame state in the cycle it is accepted; its result, if any, is registered.
// When rsp_stall holds a result, a skid register takes the next one and
// req_stall rises only while that skid register is full.
// Reset (synchronous, active high) leaves the block idle and not armed, the
// control registers at their defaults and both output registers empty.
// csr_ writes are always ready and must be issued only while idle.
module length_framed_xor_frame_receiver (
   input  logic                              clock,
   input  logic                              reset,
   // Input item channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [7:0]                        req_rx_byte,
   // Result item channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [7:0]                        rsp_data_byte,
   output logic [7:0]                        rsp_rsp_code,
   output logic [2:0]                        rsp_status,
   output logic [7:0]                        rsp_nack_error,
   output logic [15:0]                       rsp_data_count,
   // Control register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfxr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data
);

   // Control registers
   logic [7:0]  start_byte_ff;
   logic [7:0]  nack_code_ff;
   logic [15:0] first_tmo_ff;
   logic [15:0] byte_tmo_ff;
   logic [15:0] max_payload_ff;
   logic        check_enable_ff;

   // Frame state
   logic [lfxr_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [7:0]  held_rsp_ff, held_rsp_in;
   logic [7:0]  first_data_ff, first_data_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] elapsed_ff, elapsed_in;

   // Output and skid registers
   lfxr_pkg::rsp_type out_ff, skid_ff;
   logic              out_valid_ff, skid_valid_ff;

   lfxr_pkg::rsp_type res;
   logic              res_valid;
   logic              accept;
   logic              out_free;
   logic [15:0]       length_full;
   logic [15:0]       elapsed_inc;
   logic [15:0]       tmo_limit;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign length_full = {length_high_ff, req_rx_byte};
   assign elapsed_inc = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign tmo_limit   = (phase_ff == lfxr_pkg::PH_START) ? first_tmo_ff : byte_tmo_ff;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= lfxr_pkg::RST_START_BYTE;
         nack_code_ff    <= lfxr_pkg::RST_NACK_CODE;
         first_tmo_ff    <= lfxr_pkg::RST_FIRST_TMO;
         byte_tmo_ff     <= lfxr_pkg::RST_BYTE_TMO;
         max_payload_ff  <= lfxr_pkg::RST_MAX_PAYLOAD;
         check_enable_ff <= lfxr_pkg::RST_CHECK_ENABLE;
      end else if (csr_valid) begin
         unique case (csr_index)
            lfxr_pkg::CSR_START_BYTE:   start_byte_ff   <= csr_data[7:0];
            lfxr_pkg::CSR_NACK_CODE:    nack_code_ff    <= csr_data[7:0];
            lfxr_pkg::CSR_FIRST_TMO:    first_tmo_ff    <= csr_data;
            lfxr_pkg::CSR_BYTE_TMO:     byte_tmo_ff     <= csr_data;
            lfxr_pkg::CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_data;
            lfxr_pkg::CSR_CHECK_ENABLE: check_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Advance the frame state for one accepted item
   always_comb begin
      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      bytes_left_in  = bytes_left_ff;
      running_xor_in = running_xor_ff;
      held_rsp_in    = held_rsp_ff;
      first_data_in  = first_data_ff;
      count_in       = count_ff;
      elapsed_in     = elapsed_ff;
      res_valid      = 1'b0;
      res.kind       = lfxr_pkg::KIND_END;
      res.data_byte  = 8'd0;
      res.status     = lfxr_pkg::ST_OK;
      res.nack_error = 8'd0;
      if (accept) begin
         unique case (req_action)
            lfxr_pkg::ACT_ARM: begin
               phase_in       = lfxr_pkg::PH_START;
               length_high_in = 8'd0;
               bytes_left_in  = 16'd0;
               running_xor_in = 8'd0;
               held_rsp_in    = 8'd0;
               first_data_in  = 8'd0;
               count_in       = 16'd0;
               elapsed_in     = 16'd0;
            end
            lfxr_pkg::ACT_TICK: begin
               if (phase_ff != lfxr_pkg::PH_IDLE) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > tmo_limit) begin
                     res_valid  = 1'b1;
                     res.status = lfxr_pkg::ST_TIMEOUT;
                     phase_in   = lfxr_pkg::PH_IDLE;
                  end
               end
            end
            lfxr_pkg::ACT_BYTE: begin
               elapsed_in = 16'd0;
               unique case (phase_ff)
                  lfxr_pkg::PH_START: begin
                     if (req_rx_byte != start_byte_ff) begin
                        res_valid  = 1'b1;
                        res.status = lfxr_pkg::ST_BADSTART;
                        phase_in   = lfxr_pkg::PH_IDLE;
                     end else begin
                        running_xor_in = 8'd0;
                        phase_in       = lfxr_pkg::PH_LENH;
                     end
                  end
                  lfxr_pkg::PH_LENH: begin
                     length_high_in = req_rx_byte;
                     running_xor_in = running_xor_ff ^ req_rx_byte;
                     phase_in       = lfxr_pkg::PH_LENL;
                  end
                  lfxr_pkg::PH_LENL: begin
                     running_xor_in = running_xor_ff ^ req_rx_byte;
                     bytes_left_in  = length_full;
                     if (length_full > max_payload_ff) begin
                        res_valid  = 1'b1;
                        res.status = lfxr_pkg::ST_TOOLONG;
                        phase_in   = lfxr_pkg::PH_IDLE;
                     end else begin
                        phase_in = lfxr_pkg::PH_RSP;
                     end
                  end
                  lfxr_pkg::PH_RSP: begin
                     held_rsp_in    = req_rx_byte;
                     running_xor_in = running_xor_ff ^ req_rx_byte;
                     if (bytes_left_ff > 16'd1) begin
                        bytes_left_in = bytes_left_ff - 16'd1;
                        phase_in      = lfxr_pkg::PH_DATA;
                     end else begin
                        bytes_left_in = 16'd0;
                        phase_in      = lfxr_pkg::PH_CHK;
                     end
                  end
                  lfxr_pkg::PH_DATA: begin
                     if (count_ff == 16'd0) first_data_in = req_rx_byte;
                     if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
                     running_xor_in = running_xor_ff ^ req_rx_byte;
                     bytes_left_in  = bytes_left_ff - 16'd1;
                     if (bytes_left_ff == 16'd1) phase_in = lfxr_pkg::PH_CHK;
                     res_valid     = 1'b1;
                     res.kind      = lfxr_pkg::KIND_DATA;
                     res.data_byte = req_rx_byte;
                  end
                  lfxr_pkg::PH_CHK: begin
                     phase_in  = lfxr_pkg::PH_IDLE;
                     res_valid = 1'b1;
                     // checksum mismatch outranks a NACK
                     if (check_enable_ff && (req_rx_byte != running_xor_ff)) begin
                        res.status = lfxr_pkg::ST_CHKSUM;
                     end else if (held_rsp_ff == nack_code_ff) begin
                        res.status     = lfxr_pkg::ST_NACK;
                        res.nack_error = (count_ff != 16'd0) ? first_data_ff : 8'd0;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      res.rsp_code   = held_rsp_in;
      res.data_count = count_in;
   end

   // Hold the frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= lfxr_pkg::PH_IDLE;
         length_high_ff <= 8'd0;
         bytes_left_ff  <= 16'd0;
         running_xor_ff <= 8'd0;
         held_rsp_ff    <= 8'd0;
         first_data_ff  <= 8'd0;
         count_ff       <= 16'd0;
         elapsed_ff     <= 16'd0;
      end else begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         bytes_left_ff  <= bytes_left_in;
         running_xor_ff <= running_xor_in;
         held_rsp_ff    <= held_rsp_in;
         first_data_ff  <= first_data_in;
         count_ff       <= count_in;
         elapsed_ff     <= elapsed_in;
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Move payload into the output or skid register
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) out_ff <= skid_ff;
      end else if (res_valid) begin
         if (out_free) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_data_byte  = out_ff.data_byte;
   assign rsp_rsp_code   = out_ff.rsp_code;
   assign rsp_status     = out_ff.status;
   assign rsp_nack_error = out_ff.nack_error;
   assign rsp_data_count = out_ff.data_count;

endmodule

>>> hw/rtl/lfxr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module lfxr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_nack_error,
   input logic [15:0] rsp_data_count
);

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_status)
         && $stable(rsp_data_count))
      else $error("stalled result changed");

   // Data items carry no status and count themselves
   a_data_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == lfxr_pkg::KIND_DATA) |->
         (rsp_status == lfxr_pkg::ST_OK) && (rsp_nack_error == 8'd0)
         && (rsp_data_count != 16'd0))
      else $error("malformed data item");

   // NACK error byte only with a NACK status
   a_nack_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != lfxr_pkg::ST_NACK) |-> rsp_nack_error == 8'd0)
      else $error("nack error without nack status");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind length_framed_xor_frame_receiver lfxr_checker u_lfxr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_status     (rsp_status),
   .rsp_nack_error (rsp_nack_error),
   .rsp_data_count (rsp_data_count)
);

>>> tb/sv/tb_length_framed_xor_frame_receiver.sv
// Self-checking testbench for the length-framed XOR frame receiver.
`timescale 1ns / 100ps

module tb_length_framed_xor_frame_receiver;

   // Action code that the block has to ignore
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [7:0]  req_rx_byte;

   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_rsp_code;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_nack_error;
   logic [15:0] rsp_data_count;

   logic                             csr_valid;
   logic                             csr_ready;
   logic [lfxr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [15:0]                      csr_data;

   length_framed_xor_frame_receiver dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_rsp_code   (rsp_rsp_code),
      .rsp_status     (rsp_status),
      .rsp_nack_error (rsp_nack_error),
      .rsp_data_count (rsp_data_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver settings as the tracker sees them
   logic [7:0]  cfg_start;
   logic [7:0]  cfg_nack;
   logic [15:0] cfg_first_tmo;
   logic [15:0] cfg_byte_tmo;
   logic [15:0] cfg_max_len;
   logic        cfg_check;

   // Frame tracking state
   logic [2:0]  rx_phase;
   logic [7:0]  len_high_q;
   logic [15:0] bytes_left_q;
   logic [7:0]  fcs_q;
   logic [7:0]  code_held;
   logic [7:0]  first_data_q;
   logic [15:0] data_count_q;
   logic [15:0] elapsed_q;

   lfxr_pkg::rsp_type pending_results[$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   bit      calm = 1'b0;
   int      hold_request = 0;

   task automatic clear_frame_state();
      len_high_q   = '0;
      bytes_left_q = '0;
      fcs_q        = '0;
      code_held    = '0;
      first_data_q = '0;
      data_count_q = '0;
      elapsed_q    = '0;
   endtask

   function automatic lfxr_pkg::rsp_type frame_result(logic kind, logic [7:0] data,
                                                      logic [2:0] status, logic [7:0] nerr);
      lfxr_pkg::rsp_type r;
      r.kind       = kind;
      r.data_byte  = data;
      r.rsp_code   = code_held;
      r.status     = status;
      r.nack_error = nerr;
      r.data_count = data_count_q;
      return r;
   endfunction

   // Advance the frame tracker by one accepted item and queue its result
   task automatic track_frame(input logic [1:0] act, input logic [7:0] b);
      logic [15:0] limit;
      if (act == lfxr_pkg::ACT_ARM) begin
         clear_frame_state();
         rx_phase = lfxr_pkg::PH_START;
      end else if (act == lfxr_pkg::ACT_TICK) begin
         if (rx_phase != lfxr_pkg::PH_IDLE && rx_phase <= lfxr_pkg::PH_CHK) begin
            if (elapsed_q != 16'hFFFF) elapsed_q++;
            limit = (rx_phase == lfxr_pkg::PH_START) ? cfg_first_tmo : cfg_byte_tmo;
            if (elapsed_q > limit) begin
               pending_results.push_back(frame_result(lfxr_pkg::KIND_END, 8'h00,
                  lfxr_pkg::ST_TIMEOUT, 8'h00));
               rx_phase = lfxr_pkg::PH_IDLE;
            end
         end
      end else if (act == lfxr_pkg::ACT_BYTE) begin
         elapsed_q = '0;
         case (rx_phase)
            lfxr_pkg::PH_START: begin
               if (b != cfg_start) begin
                  pending_results.push_back(frame_result(lfxr_pkg::KIND_END, 8'h00,
                     lfxr_pkg::ST_BADSTART, 8'h00));
                  rx_phase = lfxr_pkg::PH_IDLE;
               end else begin
                  fcs_q = '0;
                  rx_phase = lfxr_pkg::PH_LENH;
               end
            end
            lfxr_pkg::PH_LENH: begin
               len_high_q = b;
               fcs_q ^= b;
               rx_phase = lfxr_pkg::PH_LENL;
            end
            lfxr_pkg::PH_LENL: begin
               fcs_q ^= b;
               bytes_left_q = {len_high_q, b};
               if (bytes_left_q > cfg_max_len) begin
                  pending_results.push_back(frame_result(lfxr_pkg::KIND_END, 8'h00,
                     lfxr_pkg::ST_TOOLONG, 8'h00));
                  rx_phase = lfxr_pkg::PH_IDLE;
               end else begin
                  rx_phase = lfxr_pkg::PH_RSP;
               end
            end
            lfxr_pkg::PH_RSP: begin
               code_held = b;
               fcs_q ^= b;
               bytes_left_q = (bytes_left_q > 16'd1) ? bytes_left_q - 16'd1 : 16'd0;
               rx_phase = (bytes_left_q != 16'd0) ? lfxr_pkg::PH_DATA : lfxr_pkg::PH_CHK;
            end
            lfxr_pkg::PH_DATA: begin
               if (data_count_q == 16'd0) first_data_q = b;
               if (data_count_q != 16'hFFFF) data_count_q++;
               fcs_q ^= b;
               bytes_left_q--;
               if (bytes_left_q == 16'd0) rx_phase = lfxr_pkg::PH_CHK;
               pending_results.push_back(frame_result(lfxr_pkg::KIND_DATA, b,
                  lfxr_pkg::ST_OK, 8'h00));
            end
            lfxr_pkg::PH_CHK: begin
               rx_phase = lfxr_pkg::PH_IDLE;
               // checksum error outranks a NACK
               if (cfg_check && b != fcs_q)
                  pending_results.push_back(frame_result(lfxr_pkg::KIND_END, 8'h00,
                     lfxr_pkg::ST_CHKSUM, 8'h00));
               else if (code_held == cfg_nack)
                  pending_results.push_back(frame_result(lfxr_pkg::KIND_END, 8'h00,
                     lfxr_pkg::ST_NACK, (data_count_q != 16'd0) ? first_data_q : 8'h00));
               else
                  pending_results.push_back(frame_result(lfxr_pkg::KIND_END, 8'h00,
                     lfxr_pkg::ST_OK, 8'h00));
            end
            default: begin
            end
         endcase
      end
   endtask

   // Offer one item, with random idle cycles ahead of it, and hold it until taken
   task automatic send_item(input logic [1:0] act, input logic [7:0] b);
      bit took;
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      track_frame(act, b);
      items_sent++;
   endtask

   // Send n bytes, first byte in the highest used position
   task automatic send_bytes(input int n, input logic [63:0] seq_bits);
      for (int k = 0; k < n; k++) send_item(lfxr_pkg::ACT_BYTE, seq_bits[8*(n-1-k) +: 8]);
   endtask

   // Drop valid and hold until every expected item has come back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lfxr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] val);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 1'b0;
      case (idx)
         lfxr_pkg::CSR_START_BYTE:   cfg_start     = val[7:0];
         lfxr_pkg::CSR_NACK_CODE:    cfg_nack      = val[7:0];
         lfxr_pkg::CSR_FIRST_TMO:    cfg_first_tmo = val;
         lfxr_pkg::CSR_BYTE_TMO:     cfg_byte_tmo  = val;
         lfxr_pkg::CSR_MAX_PAYLOAD:  cfg_max_len   = val;
         lfxr_pkg::CSR_CHECK_ENABLE: cfg_check     = val[0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] start_b, input logic [7:0] nack_b,
                                 input logic [15:0] first_ms, input logic [15:0] byte_ms,
                                 input logic [15:0] max_len, input logic check_on);
      wait_all_results();
      write_reg(lfxr_pkg::CSR_START_BYTE, {8'h00, start_b});
      write_reg(lfxr_pkg::CSR_NACK_CODE, {8'h00, nack_b});
      write_reg(lfxr_pkg::CSR_FIRST_TMO, first_ms);
      write_reg(lfxr_pkg::CSR_BYTE_TMO, byte_ms);
      write_reg(lfxr_pkg::CSR_MAX_PAYLOAD, max_len);
      write_reg(lfxr_pkg::CSR_CHECK_ENABLE, {15'd0, check_on});
   endtask

   // One frame with random content; a negative length picks length and faults at random
   task automatic random_frame(input int fixed_len);
      logic [15:0] flen;
      logic [7:0]  code, fcs, b;
      logic [7:0]  seq[$];
      int          pick, limit, cut_at;
      bit          over;
      pick   = $urandom_range(0, 99);
      over   = 1'b0;
      cut_at = -1;
      if (fixed_len >= 0) begin
         flen = 16'(fixed_len);
      end else if (pick < 8 && cfg_max_len != 16'hFFFF) begin
         flen = cfg_max_len + 16'($urandom_range(1, 65535 - int'(cfg_max_len)));
         over = 1'b1;
      end else if (pick < 12 && cfg_max_len <= 16'd32) begin
         flen = cfg_max_len;
      end else begin
         flen = 16'($urandom_range(0, (cfg_max_len < 16'd12) ? int'(cfg_max_len) : 12));
      end
      if (fixed_len < 0 && $urandom_range(0, 11) == 0) begin
         // likely a wrong start marker
         seq.push_back(8'($urandom));
      end else begin
         seq.push_back(cfg_start);
         seq.push_back(flen[15:8]);
         seq.push_back(flen[7:0]);
         fcs = flen[15:8] ^ flen[7:0];
         if (!over) begin
            code = ($urandom_range(0, 3) == 0) ? cfg_nack : 8'($urandom);
            seq.push_back(code);
            fcs ^= code;
            repeat ((flen > 16'd1) ? int'(flen) - 1 : 0) begin
               b = 8'($urandom);
               seq.push_back(b);
               fcs ^= b;
            end
            if (fixed_len < 0 && $urandom_range(0, 6) == 0) fcs ^= 8'(1 << $urandom_range(0, 7));
            seq.push_back(fcs);
         end
      end
      if (fixed_len < 0 && $urandom_range(0, 11) == 0) cut_at = $urandom_range(0, seq.size() - 1);
      send_item(lfxr_pkg::ACT_ARM, 8'($urandom));
      foreach (seq[i]) begin
         limit = (i == 0) ? int'(cfg_first_tmo) : int'(cfg_byte_tmo);
         // abandon the frame here, timing it out where the limit is short
         if (i == cut_at) begin
            if (limit < 300) repeat (limit + 1) send_item(lfxr_pkg::ACT_TICK, 8'($urandom));
            return;
         end
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(0, (limit < 3) ? limit : 3))
               send_item(lfxr_pkg::ACT_TICK, 8'($urandom));
         send_item(lfxr_pkg::ACT_BYTE, seq[i]);
      end
   endtask

   // Mostly well-formed frames, the rest loose items of any action
   task automatic run_random_traffic(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 75)
            random_frame(-1);
         else
            repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
   endtask

   task automatic test_idle_ignored();
      send_item(lfxr_pkg::ACT_BYTE, 8'h55);
      send_item(lfxr_pkg::ACT_TICK, 8'hFF);
      send_item(ACT_UNUSED, 8'hAA);
   endtask

   task automatic test_good_frame();
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      send_bytes(7, 64'hAA_00_03_81_FF_00_7D);
   endtask

   task automatic test_checksum_over_nack();
      send_item(lfxr_pkg::ACT_ARM, 8'hFF);
      send_bytes(6, 64'hAA_00_02_00_42_41);
   endtask

   task automatic test_nack_no_data();
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      send_bytes(5, 64'hAA_00_01_00_01);
   endtask

   task automatic test_bad_start();
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      send_item(lfxr_pkg::ACT_BYTE, 8'h55);
   endtask

   task automatic test_too_long();
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      send_bytes(3, 64'hAA_FF_FF);
   endtask

   // Re-arm inside a frame, then a zero-length frame
   task automatic test_rearm_mid_frame();
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      send_bytes(2, 64'hAA_00);
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      send_bytes(5, 64'hAA_00_00_7E_7E);
   endtask

   // Hold the result side off while a maximum-length frame streams in
   task automatic test_backpressure();
      hold_request = 60;
      calm = 1'b1;
      random_frame(int'(lfxr_pkg::RST_MAX_PAYLOAD));
      calm = 1'b0;
      wait_all_results();
   endtask

   task automatic test_calm_stretch();
      calm = 1'b1;
      run_random_traffic(70);
      calm = 1'b0;
   endtask

   // A run of ticks with the limits at maximum must not time out
   task automatic test_max_limits();
      calm = 1'b1;
      send_item(lfxr_pkg::ACT_ARM, 8'h00);
      repeat (40) send_item(lfxr_pkg::ACT_TICK, 8'($urandom));
      send_bytes(5, 64'hFF_00_01_5A_5B);
      calm = 1'b0;
   endtask

   // Compare one result field and count a mismatch
   function automatic void compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_result();
      lfxr_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("result item with none expected: kind %0d status %0d", rsp_kind, rsp_status);
         mismatch_count++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(rsp_kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(rsp_data_byte));
      compare_field("rsp_code", 16'(want.rsp_code), 16'(rsp_rsp_code));
      compare_field("status", 16'(want.status), 16'(rsp_status));
      compare_field("nack_error", 16'(want.nack_error), 16'(rsp_nack_error));
      compare_field("data_count", want.data_count, rsp_data_count);
   endtask

   // Result side: check each taken item and pick the stall for the next cycle
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_result();
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 29);
         end
      end
   end

   initial begin : main_sequence
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= lfxr_pkg::ACT_BYTE;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= lfxr_pkg::CSR_START_BYTE;
      csr_data    <= 16'h0000;
      cfg_start     = lfxr_pkg::RST_START_BYTE;
      cfg_nack      = lfxr_pkg::RST_NACK_CODE;
      cfg_first_tmo = lfxr_pkg::RST_FIRST_TMO;
      cfg_byte_tmo  = lfxr_pkg::RST_BYTE_TMO;
      cfg_max_len   = lfxr_pkg::RST_MAX_PAYLOAD;
      cfg_check     = lfxr_pkg::RST_CHECK_ENABLE;
      rx_phase      = lfxr_pkg::PH_IDLE;
      clear_frame_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset defaults
      test_idle_ignored();
      test_good_frame();
      test_checksum_over_nack();
      test_nack_no_data();
      test_bad_start();
      test_too_long();
      test_rearm_mid_frame();
      test_backpressure();
      run_random_traffic(80);

      // low extremes: instant timeouts, empty frames only, checksum ignored
      apply_settings(8'h00, 8'hFF, 16'd0, 16'd0, 16'd0, 1'b0);
      run_random_traffic(70);

      // short timeouts, mid-size frames
      apply_settings(8'($urandom), 8'($urandom), 16'd3, 16'd2, 16'd20, 1'b1);
      run_random_traffic(80);
      test_calm_stretch();

      // high extremes: timeouts never fire, any length accepted
      apply_settings(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      test_max_limits();
      run_random_traffic(55);

      wait_all_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_length_framed_xor_frame_receiver: clean");
      else
         $display("tb_length_framed_xor_frame_receiver: errors");
      $finish;
   end

   // Watchdog
   initial begin : run_limit
      #2000000;
      $display("tb_length_framed_xor_frame_receiver: errors");
      $finish;
   end

endmodule
